FILE: rtl/ntt_cc_pkg.sv
`timescale 1ns / 1ps

package ntt_cc_pkg;

    // Field widths of the request and result ports.
    localparam int COEF_W  = 30;
    localparam int INDEX_W = 12;
    localparam int FUNC_W  = 2;
    localparam int CFG_W   = 4;

    typedef logic [COEF_W-1:0] coef_t;

    // Request function codes; the last code is ignored by the block.
    localparam logic [FUNC_W-1:0] F_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] F_START  = 2'd1;
    localparam logic [FUNC_W-1:0] F_READ   = 2'd2;
    localparam logic [FUNC_W-1:0] F_UNUSED = 2'd3;

    // Field arithmetic: the prime 119 * 2^23 + 1 and its generator.
    localparam coef_t PRIME   = 30'd998244353;
    localparam coef_t GEN     = 30'd31;
    localparam int    GEN_LOG = 23;
    localparam int    SQW     = 5;

    // Barrett constant floor(2^60 / PRIME), which lies between 2^30 and 2^31.
    localparam logic [30:0] BAR_MU = 31'((64'd1 << 60) / 64'(PRIME));

    // Latency of the modular multiplier and the width of its wait counter.
    localparam int MUL_LAT = 5;
    localparam int CNT_W   = 3;

    // Default largest transform size and the reset value of log_size.
    localparam int LOG_MAX_DEF = 12;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd12;

    // Conditional subtraction of the prime from a 30-bit value.
    function automatic coef_t coef_reduce(input coef_t v);
        coef_t r;
        r = (v >= PRIME) ? v - PRIME : v;
        return r;
    endfunction

endpackage

FILE: rtl/ntt_cyclic_convolution.sv
`timescale 1ns / 1ps

// Cyclic convolution modulo 998244353 by the number theoretic transform. Load and
// read requests are taken while busy is low and may follow each other in every
// cycle; a read is answered in the cycle after it is taken. A start request holds
// busy high while the transforms of n = 2^log_size points run, each stage s first
// squaring its root 23-s times. Butterflies run one at a time, sharing the work
// memory's read and write ports and the one five-stage modular multiplier.
// The block answers a start with one result strobe carrying done_res high. Results
// cannot be held off: each appears for exactly one cycle. Configuration writes are
// taken whenever busy is low.
module ntt_cyclic_convolution #(
    parameter int LOG_MAX = ntt_cc_pkg::LOG_MAX_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ntt_cc_pkg::FUNC_W-1:0]    func,
    input  logic [ntt_cc_pkg::INDEX_W-1:0]   index,
    input  ntt_cc_pkg::coef_t                coef_a,
    input  ntt_cc_pkg::coef_t                coef_b,
    output logic                             res_valid,
    output ntt_cc_pkg::coef_t                coef_out,
    output logic                             done_res,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ntt_cc_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW    = LOG_MAX;
    localparam int DEPTH = 1 << LOG_MAX;
    localparam int LW    = $clog2(LOG_MAX + 1);
    localparam int CW    = ntt_cc_pkg::COEF_W;
    localparam int SQW_L = ntt_cc_pkg::SQW;

    // Sequencer states.
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_COPY_RD = 5'd1;
    localparam logic [4:0] S_COPY_WX = 5'd2;
    localparam logic [4:0] S_COPY_WY = 5'd3;
    localparam logic [4:0] S_STG     = 5'd4;
    localparam logic [4:0] S_TW_SQ   = 5'd5;
    localparam logic [4:0] S_TW_WAIT = 5'd6;
    localparam logic [4:0] S_BF_INIT = 5'd7;
    localparam logic [4:0] S_BF_RDV  = 5'd8;
    localparam logic [4:0] S_BF_MULV = 5'd9;
    localparam logic [4:0] S_BF_TW   = 5'd10;
    localparam logic [4:0] S_BF_WAIT = 5'd11;
    localparam logic [4:0] S_BF_WRU  = 5'd12;
    localparam logic [4:0] S_BF_WRV  = 5'd13;
    localparam logic [4:0] S_PT_RDX  = 5'd14;
    localparam logic [4:0] S_PT_RDY  = 5'd15;
    localparam logic [4:0] S_PT_MUL  = 5'd16;
    localparam logic [4:0] S_PT_WAIT = 5'd17;
    localparam logic [4:0] S_FN_RD   = 5'd18;
    localparam logic [4:0] S_FN_MUL  = 5'd19;
    localparam logic [4:0] S_FN_WAIT = 5'd20;

    // Work memory regions: both spectra, and the product in bit-reversed order.
    localparam logic [1:0] R_X = 2'd0;
    localparam logic [1:0] R_Y = 2'd1;
    localparam logic [1:0] R_Z = 2'd2;

    // Memories: loaded pairs, transform workspace and convolution results.
    logic [2*CW-1:0] load_mem [DEPTH];
    logic [CW-1:0]   work_mem [4*DEPTH];
    logic [CW-1:0]   res_mem  [DEPTH];

    logic [2*CW-1:0] ld_rd_reg;
    logic [CW-1:0]   work_rd_reg;
    logic [CW-1:0]   res_rd_reg;

    // Control registers.
    logic [4:0]                    state_reg, state_next;
    logic [AW-1:0]                 i_reg, i_next;
    logic [AW-1:0]                 b_reg, b_next;
    logic [LW-1:0]                 s_reg, s_next;
    logic [LW-1:0]                 lg_reg, lg_next;
    logic [1:0]                    tsel_reg, tsel_next;
    logic [SQW_L-1:0]              sq_reg, sq_next;
    logic [ntt_cc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ntt_cc_pkg::CFG_W-1:0]  log_size_reg;
    logic                          res_valid_reg, res_valid_next;
    logic                          done_reg, done_next;

    // Payload registers.
    ntt_cc_pkg::coef_t wl_reg, wl_next;
    ntt_cc_pkg::coef_t tw_reg, tw_next;
    ntt_cc_pkg::coef_t diff_reg, diff_next;
    ntt_cc_pkg::coef_t xv_reg, xv_next;

    // Request decoding.
    logic                  req_ok;
    logic [AW+ntt_cc_pkg::INDEX_W-1:0] idx_wide;
    logic [AW-1:0]         idx;
    logic [LW-1:0]         lg_cfg;

    assign req_ok   = start && !busy;
    assign idx_wide = {{AW{1'b0}}, index};
    assign idx      = idx_wide[AW-1:0];

    // The transform length is clamped to 1..LOG_MAX when a start is taken.
    always_comb
    begin
        if (log_size_reg == '0)
            lg_cfg = LW'(1);
        else if (int'(log_size_reg) > LOG_MAX)
            lg_cfg = LW'(LOG_MAX);
        else
            lg_cfg = LW'(log_size_reg);
    end

    // Index arithmetic for copying, butterflies and the final reordering.
    logic [AW-1:0] nmask, hmask, half, u_addr, v_addr, fidx, rev_full, rev_i;
    logic [LW-1:0] s_dec;

    assign s_dec  = s_reg - LW'(1);
    assign nmask  = ~({AW{1'b1}} << lg_reg);
    assign hmask  = ~({AW{1'b1}} << s_dec);
    assign half   = AW'(1) << s_dec;
    assign u_addr = ((b_reg & ~hmask) << 1) | (b_reg & hmask);
    assign v_addr = u_addr | half;
    assign fidx   = (AW'(0) - i_reg) & nmask;

    always_comb
    begin
        for (int k = 0; k < AW; k++)
            rev_full[k] = i_reg[AW-1-k];
    end

    assign rev_i = rev_full >> (LW'(AW) - lg_reg);

    // Shared pipelined modular multiplier (Barrett reduction).
    ntt_cc_pkg::coef_t mul_a, mul_b, mul_r;
    logic [59:0] m1_prod_reg;
    logic [61:0] m2_q2_reg;
    logic [31:0] m2_lo_reg;
    logic [31:0] m3_qp_reg;
    logic [31:0] m3_lo_reg;
    logic [31:0] m4_r_reg;
    logic [30:0] q3;
    logic [31:0] r_raw;
    logic [31:0] two_p;
    logic [31:0] prime32;

    assign q3      = m2_q2_reg[61:31];
    assign prime32 = {2'b00, ntt_cc_pkg::PRIME};
    assign two_p   = prime32 << 1;
    assign r_raw   = m3_lo_reg - m3_qp_reg;

    always_ff @(posedge clk)
    begin
        m1_prod_reg <= {30'b0, mul_a} * {30'b0, mul_b};
        m2_q2_reg   <= {31'b0, m1_prod_reg[59:29]} * {31'b0, ntt_cc_pkg::BAR_MU};
        m2_lo_reg   <= m1_prod_reg[31:0];
        m3_qp_reg   <= {1'b0, q3} * prime32;
        m3_lo_reg   <= m2_lo_reg;
        m4_r_reg    <= (r_raw >= two_p) ? r_raw - two_p : r_raw;
        mul_r       <= (m4_r_reg >= prime32) ? CW'(m4_r_reg - prime32) : CW'(m4_r_reg);
    end

    // Butterfly sum and difference.
    logic [CW:0]       bf_sum;
    ntt_cc_pkg::coef_t bf_add, bf_sub, inv_n;

    assign bf_sum = {1'b0, work_rd_reg} + {1'b0, mul_r};
    assign bf_add = (bf_sum >= {1'b0, ntt_cc_pkg::PRIME}) ?
                    CW'(bf_sum - {1'b0, ntt_cc_pkg::PRIME}) : CW'(bf_sum);
    assign bf_sub = (work_rd_reg >= mul_r) ? work_rd_reg - mul_r :
                    work_rd_reg + ntt_cc_pkg::PRIME - mul_r;

    // n^-1 is PRIME - (PRIME - 1) / n since n divides PRIME - 1.
    assign inv_n = ntt_cc_pkg::PRIME - ((ntt_cc_pkg::PRIME - CW'(1)) >> lg_reg);

    // Memory port control.
    logic              ld_we;
    logic [AW-1:0]     work_raddr_lo, work_waddr_lo;
    logic [1:0]        work_rreg, work_wreg;
    logic              work_we;
    ntt_cc_pkg::coef_t work_wdata;
    logic              res_we;

    assign ld_we = req_ok && (func == ntt_cc_pkg::F_LOAD);

    always_ff @(posedge clk)
    begin
        if (ld_we)
            load_mem[idx] <= {ntt_cc_pkg::coef_reduce(coef_b),
                              ntt_cc_pkg::coef_reduce(coef_a)};
        ld_rd_reg <= load_mem[i_reg];
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
            work_mem[{work_wreg, work_waddr_lo}] <= work_wdata;
        work_rd_reg <= work_mem[{work_rreg, work_raddr_lo}];
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
            res_mem[i_reg] <= mul_r;
        res_rd_reg <= res_mem[idx];
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        b_next         = b_reg;
        s_next         = s_reg;
        lg_next        = lg_reg;
        tsel_next      = tsel_reg;
        sq_next        = sq_reg;
        cnt_next       = cnt_reg;
        wl_next        = wl_reg;
        tw_next        = tw_reg;
        diff_next      = diff_reg;
        xv_next        = xv_reg;
        res_valid_next = 1'b0;
        done_next      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        work_rreg      = tsel_reg;
        work_raddr_lo  = u_addr;
        work_wreg      = tsel_reg;
        work_waddr_lo  = u_addr;
        work_we        = 1'b0;
        work_wdata     = bf_add;
        res_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_ok && (func == ntt_cc_pkg::F_READ))
                    res_valid_next = 1'b1;
                if (req_ok && (func == ntt_cc_pkg::F_START))
                begin
                    lg_next    = lg_cfg;
                    i_next     = '0;
                    state_next = S_COPY_RD;
                end
            end

            // Copy both loaded sequences into bit-reversed order.
            S_COPY_RD:
                state_next = S_COPY_WX;
            S_COPY_WX:
            begin
                work_we       = 1'b1;
                work_wreg     = R_X;
                work_waddr_lo = rev_i;
                work_wdata    = ld_rd_reg[CW-1:0];
                state_next    = S_COPY_WY;
            end
            S_COPY_WY:
            begin
                work_we       = 1'b1;
                work_wreg     = R_Y;
                work_waddr_lo = rev_i;
                work_wdata    = ld_rd_reg[2*CW-1:CW];
                if (i_reg == nmask)
                begin
                    tsel_next  = R_X;
                    s_next     = LW'(1);
                    state_next = S_STG;
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = S_COPY_RD;
                end
            end

            // Stage root 31^(2^(23-s)) by repeated squaring.
            S_STG:
            begin
                wl_next = ntt_cc_pkg::GEN;
                sq_next = SQW_L'(ntt_cc_pkg::GEN_LOG) - SQW_L'(s_reg);
                if (SQW_L'(ntt_cc_pkg::GEN_LOG) == SQW_L'(s_reg))
                    state_next = S_BF_INIT;
                else
                    state_next = S_TW_SQ;
            end
            S_TW_SQ:
            begin
                mul_a      = wl_reg;
                mul_b      = wl_reg;
                cnt_next   = ntt_cc_pkg::CNT_W'(ntt_cc_pkg::MUL_LAT - 1);
                state_next = S_TW_WAIT;
            end
            S_TW_WAIT:
            begin
                if (cnt_reg == '0)
                begin
                    wl_next = mul_r;
                    sq_next = sq_reg - SQW_L'(1);
                    if (sq_reg == SQW_L'(1))
                        state_next = S_BF_INIT;
                    else
                        state_next = S_TW_SQ;
                end
                else
                    cnt_next = cnt_reg - ntt_cc_pkg::CNT_W'(1);
            end

            // Butterflies of one stage, one at a time.
            S_BF_INIT:
            begin
                b_next     = '0;
                tw_next    = ntt_cc_pkg::coef_t'(1);
                state_next = S_BF_RDV;
            end
            S_BF_RDV:
            begin
                work_raddr_lo = v_addr;
                state_next    = S_BF_MULV;
            end
            S_BF_MULV:
            begin
                mul_a      = tw_reg;
                mul_b      = work_rd_reg;
                state_next = S_BF_TW;
            end
            S_BF_TW:
            begin
                mul_a      = tw_reg;
                mul_b      = wl_reg;
                cnt_next   = ntt_cc_pkg::CNT_W'(ntt_cc_pkg::MUL_LAT - 3);
                state_next = S_BF_WAIT;
            end
            S_BF_WAIT:
            begin
                if (cnt_reg == '0)
                    state_next = S_BF_WRU;
                else
                    cnt_next = cnt_reg - ntt_cc_pkg::CNT_W'(1);
            end
            S_BF_WRU:
            begin
                work_we    = 1'b1;
                work_wdata = bf_add;
                diff_next  = bf_sub;
                state_next = S_BF_WRV;
            end
            S_BF_WRV:
            begin
                work_we       = 1'b1;
                work_waddr_lo = v_addr;
                work_wdata    = diff_reg;
                if ((b_reg & hmask) == hmask)
                    tw_next = ntt_cc_pkg::coef_t'(1);
                else
                    tw_next = mul_r;
                if (b_reg == (nmask >> 1))
                begin
                    if (s_reg != lg_reg)
                    begin
                        s_next     = s_reg + LW'(1);
                        state_next = S_STG;
                    end
                    else if (tsel_reg == R_X)
                    begin
                        tsel_next  = R_Y;
                        s_next     = LW'(1);
                        state_next = S_STG;
                    end
                    else if (tsel_reg == R_Y)
                    begin
                        i_next     = '0;
                        state_next = S_PT_RDX;
                    end
                    else
                    begin
                        i_next     = '0;
                        state_next = S_FN_RD;
                    end
                end
                else
                begin
                    b_next     = b_reg + AW'(1);
                    state_next = S_BF_RDV;
                end
            end

            // Pointwise product, stored bit-reversed for the last transform.
            S_PT_RDX:
            begin
                work_rreg     = R_X;
                work_raddr_lo = i_reg;
                state_next    = S_PT_RDY;
            end
            S_PT_RDY:
            begin
                work_rreg     = R_Y;
                work_raddr_lo = i_reg;
                xv_next       = work_rd_reg;
                state_next    = S_PT_MUL;
            end
            S_PT_MUL:
            begin
                mul_a      = xv_reg;
                mul_b      = work_rd_reg;
                cnt_next   = ntt_cc_pkg::CNT_W'(ntt_cc_pkg::MUL_LAT - 1);
                state_next = S_PT_WAIT;
            end
            S_PT_WAIT:
            begin
                if (cnt_reg == '0)
                begin
                    work_we       = 1'b1;
                    work_wreg     = R_Z;
                    work_waddr_lo = rev_i;
                    work_wdata    = mul_r;
                    if (i_reg == nmask)
                    begin
                        tsel_next  = R_Z;
                        s_next     = LW'(1);
                        state_next = S_STG;
                    end
                    else
                    begin
                        i_next     = i_reg + AW'(1);
                        state_next = S_PT_RDX;
                    end
                end
                else
                    cnt_next = cnt_reg - ntt_cc_pkg::CNT_W'(1);
            end

            // The inverse transform is the forward one read at index -i, scaled by 1/n.
            S_FN_RD:
            begin
                work_rreg     = R_Z;
                work_raddr_lo = fidx;
                state_next    = S_FN_MUL;
            end
            S_FN_MUL:
            begin
                mul_a      = work_rd_reg;
                mul_b      = inv_n;
                cnt_next   = ntt_cc_pkg::CNT_W'(ntt_cc_pkg::MUL_LAT - 1);
                state_next = S_FN_WAIT;
            end
            S_FN_WAIT:
            begin
                if (cnt_reg == '0)
                begin
                    res_we = 1'b1;
                    if (i_reg == nmask)
                    begin
                        res_valid_next = 1'b1;
                        done_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + AW'(1);
                        state_next = S_FN_RD;
                    end
                end
                else
                    cnt_next = cnt_reg - ntt_cc_pkg::CNT_W'(1);
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            log_size_reg  <= ntt_cc_pkg::CFG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            done_reg      <= done_next;
            if (cfg_valid && cfg_ready)
                log_size_reg <= cfg_data;
        end
    end

    // Counters and data registers of the sequencer.
    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        b_reg    <= b_next;
        s_reg    <= s_next;
        lg_reg   <= lg_next;
        tsel_reg <= tsel_next;
        sq_reg   <= sq_next;
        cnt_reg  <= cnt_next;
        wl_reg   <= wl_next;
        tw_reg   <= tw_next;
        diff_reg <= diff_next;
        xv_reg   <= xv_next;
    end

    // Outputs.
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign res_valid = res_valid_reg;
    assign done_res  = done_reg;
    assign coef_out  = done_reg ? '0 : res_rd_reg;

endmodule

FILE: rtl/ntt_cc_chk.sv
`timescale 1ns / 1ps

module ntt_cc_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [ntt_cc_pkg::FUNC_W-1:0] func,
    input logic                          res_valid,
    input logic                          done_res,
    input ntt_cc_pkg::coef_t             coef_out
);

    // A completed start answers with a zero coefficient.
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> coef_out == '0)
        else $error("done result carries a nonzero coefficient");

    // The end of a convolution run is marked by the done result.
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> res_valid && done_res)
        else $error("busy fell without a done result");

    // A read request is answered in the next cycle.
    a_read_resp: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && func == ntt_cc_pkg::F_READ |=> res_valid && !done_res)
        else $error("read request not answered");

    // Loads and unused codes produce no result.
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (func == ntt_cc_pkg::F_LOAD || func == ntt_cc_pkg::F_UNUSED)
        |=> !res_valid)
        else $error("result after a load request");

endmodule

bind ntt_cyclic_convolution ntt_cc_chk u_ntt_cc_chk (.*);
